// ===== rtl/core/eac_pkg.sv =====
// Package for the encoder angle conversion block: widths, constants, codes,
// the controller/datapath command and status structs and the angle clamp.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none
package eac_pkg;

   localparam int SAMPLE_W    = 16;
   localparam int COUNT_W     = 13;
   localparam int ANGLE_W     = 19;
   localparam int MAP_IDX_W   = 7;
   localparam int NUM_SAMPLES = 5;

   localparam int DEF_LEFT_MAP_DEPTH  = 64;
   localparam int DEF_RIGHT_MAP_DEPTH = 61;
   localparam int DEF_BASE_MAP_DEPTH  = 101;

   localparam logic [1:0] CH_LEFT  = 2'd0;
   localparam logic [1:0] CH_RIGHT = 2'd1;
   localparam logic [1:0] CH_BASE  = 2'd2;
   localparam logic [1:0] CH_NONE  = 2'd3;

   localparam logic OP_CONVERT   = 1'b0;
   localparam logic OP_MAP_WRITE = 1'b1;

   localparam logic MODE_REF   = 1'b0;
   localparam logic MODE_TABLE = 1'b1;

   localparam logic [1:0] CSR_MODE      = 2'd0;
   localparam logic [1:0] CSR_REF_LEFT  = 2'd1;
   localparam logic [1:0] CSR_REF_RIGHT = 2'd2;
   localparam logic [1:0] CSR_REF_BASE  = 2'd3;

   // point-B angles, Q16 degrees
   localparam logic [23:0] PB_LEFT_Q16  = 24'd2146889;
   localparam logic [23:0] PB_RIGHT_Q16 = 24'd5831428;
   localparam logic [23:0] PB_BASE_Q16  = 24'd5898240;

   localparam logic [12:0] MEAN_LIMIT   = 13'd4096;
   localparam logic [12:0] DEG_PER_CNT  = 13'd5760;   // 360/4096 in Q16
   localparam logic [12:0] SEG_WRAP     = 13'd4095;
   localparam logic [16:0] RECIP3       = 17'd43691;  // ceil(2^17/3)
   localparam logic [26:0] RECIP5       = 27'd107374183; // ceil(2^29/5)
   localparam logic [7:0]  INTERP_GAIN  = 8'd225;
   localparam logic [13:0] SEG_STEP2    = 14'd9216;
   localparam logic [12:0] SEG_STEP     = 13'd4608;
   localparam logic [19:0] LEFT_TOP     = 20'd589824;
   localparam logic [3:0]  ROUND_BIAS   = 4'd10;

   typedef struct packed {
      logic accept;
      logic mean_a;
      logic mean_b;
      logic ref_a;
      logic ref_b;
      logic tbl_rd0;
      logic tbl_rd1;
      logic tbl_walk;
      logic tbl_x;
      logic tbl_y;
      logic tbl_div;
      logic finish;
   } cmd_type;

   typedef struct packed {
      logic mode_table;
      logic walk_done;
   } status_type;

   function automatic logic signed [ANGLE_W-1:0] sat_angle(input logic signed [29:0] v);
      logic signed [ANGLE_W-1:0] r;
      if (v > 30'sd262143) begin
         r = 19'sh3FFFF;
      end else if (v < -30'sd262144) begin
         r = 19'sh40000;
      end else begin
         r = v[ANGLE_W-1:0];
      end
      return r;
   endfunction

endpackage
`default_nettype wire

// ===== rtl/core/eac_map_ram.sv =====
// Calibration map storage for one channel: one write port, one registered read.
// Depends on eac_pkg.
`timescale 1ns / 1ps
`default_nettype none
module eac_map_ram
   import eac_pkg::*;
#(
   parameter int DEPTH = DEF_LEFT_MAP_DEPTH
) (
   input  wire logic                 clock,
   input  wire logic                 wr_en,
   input  wire logic [MAP_IDX_W-1:0] wr_addr,
   input  wire logic [COUNT_W-1:0]   wr_data,
   input  wire logic                 rd_en,
   input  wire logic [MAP_IDX_W-1:0] rd_addr,
   output logic      [COUNT_W-1:0]   rd_data
);
   localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam logic [MAP_IDX_W:0] DepthL = (MAP_IDX_W + 1)'(DEPTH);

   logic [COUNT_W-1:0] mem [DEPTH];
   logic [COUNT_W-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en && ({1'b0, wr_addr} < DepthL)) begin
         mem[wr_addr[AW-1:0]] <= wr_data;
      end
      if (rd_en && ({1'b0, rd_addr} < DepthL)) begin
         rd_data_ff <= mem[rd_addr[AW-1:0]];
      end
   end

   assign rd_data = rd_data_ff;
endmodule
`default_nettype wire

// ===== rtl/core/eac_ctrl.sv =====
// Sequencer for the conversion: mean, reference or table path, result hand-off.
// Depends on eac_pkg.
`timescale 1ns / 1ps
`default_nettype none
module eac_ctrl
   import eac_pkg::*;
(
   input  wire logic       clock,
   input  wire logic       reset,
   input  wire logic       req_valid,
   input  wire logic       req_operation,
   input  wire logic [1:0] req_channel,
   output logic            req_ready,
   output logic            rsp_valid,
   input  wire logic       rsp_ready,
   input  wire status_type status,
   output cmd_type         cmd
);
   typedef enum logic [11:0] {
      ST_IDLE     = 12'b000000000001,
      ST_MEAN_A   = 12'b000000000010,
      ST_MEAN_B   = 12'b000000000100,
      ST_REF_A    = 12'b000000001000,
      ST_REF_B    = 12'b000000010000,
      ST_TBL_RD0  = 12'b000000100000,
      ST_TBL_RD1  = 12'b000001000000,
      ST_TBL_WALK = 12'b000010000000,
      ST_TBL_X    = 12'b000100000000,
      ST_TBL_Y    = 12'b001000000000,
      ST_TBL_DIV  = 12'b010000000000,
      ST_FIN      = 12'b100000000000
   } state_type;

   state_type state_ff, state_in;
   logic      rsp_valid_ff, rsp_valid_in;
   logic      out_free, accept;

   assign out_free  = !rsp_valid_ff || rsp_ready;
   assign req_ready = (state_ff == ST_IDLE);
   assign accept    = req_valid && req_ready;
   assign rsp_valid = rsp_valid_ff;

   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      cmd.accept = accept;
      case (state_ff)
         ST_IDLE: begin
            if (accept && req_operation == OP_CONVERT && req_channel != CH_NONE) begin
               state_in = ST_MEAN_A;
            end
         end
         ST_MEAN_A: begin
            cmd.mean_a = 1'b1;
            state_in   = ST_MEAN_B;
         end
         ST_MEAN_B: begin
            cmd.mean_b = 1'b1;
            state_in   = status.mode_table ? ST_TBL_RD0 : ST_REF_A;
         end
         ST_REF_A: begin
            cmd.ref_a = 1'b1;
            state_in  = ST_REF_B;
         end
         ST_REF_B: begin
            cmd.ref_b = 1'b1;
            state_in  = ST_FIN;
         end
         ST_TBL_RD0: begin
            cmd.tbl_rd0 = 1'b1;
            state_in    = ST_TBL_RD1;
         end
         ST_TBL_RD1: begin
            cmd.tbl_rd1 = 1'b1;
            state_in    = ST_TBL_WALK;
         end
         ST_TBL_WALK: begin
            cmd.tbl_walk = 1'b1;
            if (status.walk_done) begin
               state_in = ST_TBL_X;
            end
         end
         ST_TBL_X: begin
            cmd.tbl_x = 1'b1;
            state_in  = ST_TBL_Y;
         end
         ST_TBL_Y: begin
            cmd.tbl_y = 1'b1;
            state_in  = ST_TBL_DIV;
         end
         ST_TBL_DIV: begin
            cmd.tbl_div = 1'b1;
            state_in    = ST_FIN;
         end
         ST_FIN: begin
            if (out_free) begin
               cmd.finish = 1'b1;
               state_in   = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (rsp_valid_ff && rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
      if (cmd.finish) begin
         rsp_valid_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

`ifndef SYNTHESIS
   a_fin_needs_room: assert property (@(posedge clock) disable iff (reset)
      cmd.finish |-> (!rsp_valid_ff || rsp_ready))
      else $error("result loaded over an untaken result");

   a_convert_starts: assert property (@(posedge clock) disable iff (reset)
      (accept && req_operation == OP_CONVERT && req_channel != CH_NONE)
      |=> state_ff == ST_MEAN_A)
      else $error("convert transaction did not start the mean");

   a_rsp_from_fin: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(state_ff == ST_FIN))
      else $error("result raised outside finish");

   a_busy_not_ready: assert property (@(posedge clock) disable iff (reset)
      (state_ff != ST_IDLE) |-> !req_ready)
      else $error("ready while busy");
`endif

endmodule
`default_nettype wire

// ===== rtl/core/eac_dpath.sv =====
// Datapath: item registers, trimmed mean, reference and table arithmetic,
// calibration maps, configuration registers and result registers. Depends on eac_pkg.
`timescale 1ns / 1ps
`default_nettype none
module eac_dpath
   import eac_pkg::*;
#(
   parameter int LEFT_MAP_DEPTH  = DEF_LEFT_MAP_DEPTH,
   parameter int RIGHT_MAP_DEPTH = DEF_RIGHT_MAP_DEPTH,
   parameter int BASE_MAP_DEPTH  = DEF_BASE_MAP_DEPTH
) (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire cmd_type               cmd,
   output status_type                 status,
   input  wire logic                  req_operation,
   input  wire logic [1:0]            req_channel,
   input  wire logic [SAMPLE_W-1:0]   req_sample_0,
   input  wire logic [SAMPLE_W-1:0]   req_sample_1,
   input  wire logic [SAMPLE_W-1:0]   req_sample_2,
   input  wire logic [SAMPLE_W-1:0]   req_sample_3,
   input  wire logic [SAMPLE_W-1:0]   req_sample_4,
   input  wire logic [MAP_IDX_W-1:0]  req_map_index,
   input  wire logic [COUNT_W-1:0]    req_map_value,
   input  wire logic                  csr_write,
   input  wire logic [1:0]            csr_index,
   input  wire logic [COUNT_W-1:0]    csr_data,
   output logic [1:0]                 rsp_result_channel,
   output logic [COUNT_W-1:0]         rsp_mean_value,
   output logic signed [ANGLE_W-1:0]  rsp_angle_q8
);
   localparam logic [MAP_IDX_W-1:0] LeftLast  = MAP_IDX_W'(LEFT_MAP_DEPTH - 1);
   localparam logic [MAP_IDX_W-1:0] RightLast = MAP_IDX_W'(RIGHT_MAP_DEPTH - 1);
   localparam logic [MAP_IDX_W-1:0] BaseLast  = MAP_IDX_W'(BASE_MAP_DEPTH - 1);

   // configuration
   logic               mode_ff;
   logic [COUNT_W-1:0] ref_left_ff, ref_right_ff, ref_base_ff;

   // item and working registers
   logic [1:0]           ch_ff;
   logic [SAMPLE_W-1:0]  smp_ff [NUM_SAMPLES];
   logic signed [17:0]   d_ff, d_in;
   logic [COUNT_W-1:0]   m_ff, m_in;
   logic signed [14:0]   off_ff, off_in;
   logic signed [29:0]   acc_ff, acc_in;
   logic [COUNT_W-1:0]   prev_ff;
   logic [MAP_IDX_W-1:0] i_ff, seg_ff;
   logic [13:0]          h_ff, t_ff, h_w, t_w;
   logic signed [25:0]   x_ff, x_in;
   logic [25:0]          z_ff, z_in;
   logic [52:0]          prod_ff;

   // result registers
   logic [1:0]                rch_ff;
   logic [COUNT_W-1:0]        rmean_ff;
   logic signed [ANGLE_W-1:0] rang_ff, rang_in;

   // maps
   logic [COUNT_W-1:0]   rd_left, rd_right, rd_base, rd_data;
   logic [MAP_IDX_W-1:0] rd_addr;
   logic                 rd_en, map_wr;
   logic                 hit, last;
   logic [MAP_IDX_W-1:0] last_seg, last_i;

   assign map_wr = cmd.accept && req_operation == OP_MAP_WRITE;
   assign rd_en  = cmd.tbl_rd0 || cmd.tbl_rd1 || cmd.tbl_walk;

   always_comb begin
      rd_addr = MAP_IDX_W'(i_ff + MAP_IDX_W'(2));
      if (cmd.tbl_rd0) begin
         rd_addr = '0;
      end else if (cmd.tbl_rd1) begin
         rd_addr = MAP_IDX_W'(1);
      end
   end

   eac_map_ram #(.DEPTH(LEFT_MAP_DEPTH)) u_left_map (
      .clock, .wr_en(map_wr && req_channel == CH_LEFT), .wr_addr(req_map_index),
      .wr_data(req_map_value), .rd_en, .rd_addr, .rd_data(rd_left));
   eac_map_ram #(.DEPTH(RIGHT_MAP_DEPTH)) u_right_map (
      .clock, .wr_en(map_wr && req_channel == CH_RIGHT), .wr_addr(req_map_index),
      .wr_data(req_map_value), .rd_en, .rd_addr, .rd_data(rd_right));
   eac_map_ram #(.DEPTH(BASE_MAP_DEPTH)) u_base_map (
      .clock, .wr_en(map_wr && req_channel == CH_BASE), .wr_addr(req_map_index),
      .wr_data(req_map_value), .rd_en, .rd_addr, .rd_data(rd_base));

   always_comb begin
      case (ch_ff)
         CH_LEFT:  begin rd_data = rd_left;  last_seg = LeftLast;  end
         CH_RIGHT: begin rd_data = rd_right; last_seg = RightLast; end
         default:  begin rd_data = rd_base;  last_seg = BaseLast;  end
      endcase
      last_i = last_seg - MAP_IDX_W'(1);
   end

   // trimmed mean, stage A: wrapped sum, max, min
   always_comb begin
      logic [SAMPLE_W-1:0] sum, mx, mn;
      sum = '0;
      mx  = '0;
      mn  = '1;
      for (int k = 0; k < NUM_SAMPLES; k++) begin
         sum = sum + smp_ff[k];
         if (smp_ff[k] > mx) mx = smp_ff[k];
         if (smp_ff[k] < mn) mn = smp_ff[k];
      end
      d_in = $signed({2'b00, sum}) - $signed({2'b00, mx}) - $signed({2'b00, mn});
   end

   // stage B: divide by three, out-of-range mean reads as zero
   always_comb begin
      logic [32:0] p;
      logic [15:0] q;
      p = 33'(d_ff[15:0]) * 33'(RECIP3);
      q = p[32:17];
      if (d_ff[17] || q > 16'(MEAN_LIMIT)) begin
         m_in = '0;
      end else begin
         m_in = q[COUNT_W-1:0];
      end
   end

   // reference path: wrap reference to within half a turn, then scale
   always_comb begin
      logic [COUNT_W-1:0] r;
      logic signed [14:0] dl;
      logic [23:0]        b;
      case (ch_ff)
         CH_LEFT:  begin r = ref_left_ff;  b = PB_LEFT_Q16;  end
         CH_RIGHT: begin r = ref_right_ff; b = PB_RIGHT_Q16; end
         default:  begin r = ref_base_ff;  b = PB_BASE_Q16;  end
      endcase
      dl = $signed({2'b00, r}) - $signed({2'b00, m_ff});
      if (dl > 15'sd2048) begin
         off_in = dl - 15'sd4096;
      end else if (dl < -15'sd2048) begin
         off_in = dl + 15'sd4096;
      end else begin
         off_in = dl;
      end
      acc_in = $signed({6'b0, b})
             - $signed({{15{off_ff[14]}}, off_ff}) * $signed({17'b0, DEG_PER_CNT})
             + 30'sd128;
   end

   // table walk: segment [prev, rd_data] with per-channel wrap rule
   always_comb begin
      logic [13:0] m14;
      m14 = {1'b0, m_ff};
      h_w = {1'b0, prev_ff};
      t_w = {1'b0, rd_data};
      if (ch_ff == CH_LEFT) begin
         if (prev_ff > rd_data) t_w = t_w + 14'(SEG_WRAP);
         hit = (m14 <= t_w) && (m14 >= h_w);
      end else begin
         if (rd_data > prev_ff) h_w = h_w + 14'(SEG_WRAP);
         if (ch_ff == CH_RIGHT) begin
            hit = (m14 <= h_w) && (m14 >= t_w);
         end else begin
            hit = (m14 <= h_w) && (m14 > t_w);
         end
      end
      last = (i_ff == last_i);
   end

   // interpolation and floor((x + 10) / 20) as floor(floor(y/4) / 5)
   always_comb begin
      logic signed [16:0] diff;
      logic [20:0]        st;
      logic signed [22:0] base;
      logic signed [25:0] y;
      logic signed [23:0] y4;
      diff = $signed({3'b0, h_ff}) + $signed({3'b0, t_ff}) - $signed({2'b0, m_ff, 1'b0});
      x_in = $signed({{9{diff[16]}}, diff}) * $signed({18'b0, INTERP_GAIN});
      st   = 21'(seg_ff) * 21'(SEG_STEP2) + 21'(SEG_STEP);
      case (ch_ff)
         CH_LEFT:  base = $signed({3'b0, LEFT_TOP}) - $signed({2'b0, st});
         CH_RIGHT: base = $signed({2'b0, st}) - $signed({9'b0, SEG_STEP2});
         default:  base = $signed({2'b0, st});
      endcase
      y    = x_ff + $signed({{3{base[22]}}, base}) + $signed({22'b0, ROUND_BIAS});
      y4   = y[25:2];
      z_in = 26'($signed({{2{y4[23]}}, y4}) + 26'sd41943040);
   end

   always_comb begin
      logic [23:0]        qu;
      logic signed [24:0] q;
      qu = prod_ff[52:29];
      q  = $signed({1'b0, qu}) - 25'sd8388608;
      if (mode_ff == MODE_TABLE) begin
         rang_in = sat_angle({{5{q[24]}}, q});
      end else begin
         rang_in = sat_angle(acc_ff >>> 8);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff      <= MODE_REF;
         ref_left_ff  <= '0;
         ref_right_ff <= '0;
         ref_base_ff  <= '0;
      end else if (csr_write) begin
         case (csr_index)
            CSR_MODE:      mode_ff      <= csr_data[0];
            CSR_REF_LEFT:  ref_left_ff  <= csr_data;
            CSR_REF_RIGHT: ref_right_ff <= csr_data;
            CSR_REF_BASE:  ref_base_ff  <= csr_data;
            default:       mode_ff      <= mode_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.accept) begin
         ch_ff     <= req_channel;
         smp_ff[0] <= req_sample_0;
         smp_ff[1] <= req_sample_1;
         smp_ff[2] <= req_sample_2;
         smp_ff[3] <= req_sample_3;
         smp_ff[4] <= req_sample_4;
      end
      if (cmd.mean_a) d_ff   <= d_in;
      if (cmd.mean_b) m_ff   <= m_in;
      if (cmd.ref_a)  off_ff <= off_in;
      if (cmd.ref_b)  acc_ff <= acc_in;
      if (cmd.tbl_rd1) begin
         prev_ff <= rd_data;
         i_ff    <= '0;
      end
      if (cmd.tbl_walk) begin
         prev_ff <= rd_data;
         i_ff    <= i_ff + MAP_IDX_W'(1);
         h_ff    <= h_w;
         t_ff    <= t_w;
         seg_ff  <= hit ? i_ff : last_seg;   // no bracket: index past the last segment
      end
      if (cmd.tbl_x)   x_ff    <= x_in;
      if (cmd.tbl_y)   z_ff    <= z_in;
      if (cmd.tbl_div) prod_ff <= 53'(z_ff) * 53'(RECIP5);
      if (cmd.finish) begin
         rch_ff   <= ch_ff;
         rmean_ff <= m_ff;
         rang_ff  <= rang_in;
      end
   end

   assign status.mode_table = (mode_ff == MODE_TABLE);
   assign status.walk_done  = hit || last;

   assign rsp_result_channel = rch_ff;
   assign rsp_mean_value     = rmean_ff;
   assign rsp_angle_q8       = rang_ff;

endmodule
`default_nettype wire

// ===== rtl/core/encoder_angle_conversion_unit.sv =====
// Top level of the encoder angle conversion block: controller plus datapath.
// Depends on eac_pkg, eac_ctrl, eac_dpath (which holds eac_map_ram).
//
// Usage:
//  - req_* (valid/ready): a transaction is a convert (five raw readings of one
//    channel) or a map write; map writes and channel 3 give no result.
//  - rsp_* (valid/ready): one transaction per convert on channels 0..2 with the
//    channel, the trimmed mean and the signed Q8 angle.
//  - csr_*: register writes (mode, three reference counts); csr_ready is always
//    high. Write only while the block is idle.
// From accept to rsp_valid the controller steps through mean A and B, then
// reference A and B (reference mode) or map reads 0 and 1, a walk over k
// segments (k = 1 .. depth-1, one map read per cycle from a single port), X, Y
// and the divide (table mode), then the result load. One conversion is in
// flight; req_ready is high only when idle, so a new convert can be taken in
// the cycle after the result load. If the receiver stalls, the next conversion
// runs but holds before its own result load until rsp is taken.
// Reset clears the configuration to reference mode with zero references and
// returns the controller to idle. Map contents are not cleared.
`timescale 1ns / 1ps
`default_nettype none
module encoder_angle_conversion_unit
   import eac_pkg::*;
#(
   parameter int LEFT_MAP_DEPTH  = DEF_LEFT_MAP_DEPTH,
   parameter int RIGHT_MAP_DEPTH = DEF_RIGHT_MAP_DEPTH,
   parameter int BASE_MAP_DEPTH  = DEF_BASE_MAP_DEPTH
) (
   input  wire logic                  clock,
   input  wire logic                  reset,
   // input transactions
   input  wire logic                  req_valid,
   output logic                       req_ready,
   input  wire logic                  req_operation,
   input  wire logic [1:0]            req_channel,
   input  wire logic [SAMPLE_W-1:0]   req_sample_0,
   input  wire logic [SAMPLE_W-1:0]   req_sample_1,
   input  wire logic [SAMPLE_W-1:0]   req_sample_2,
   input  wire logic [SAMPLE_W-1:0]   req_sample_3,
   input  wire logic [SAMPLE_W-1:0]   req_sample_4,
   input  wire logic [MAP_IDX_W-1:0]  req_map_index,
   input  wire logic [COUNT_W-1:0]    req_map_value,
   // result transactions
   output logic                       rsp_valid,
   input  wire logic                  rsp_ready,
   output logic [1:0]                 rsp_result_channel,
   output logic [COUNT_W-1:0]         rsp_mean_value,
   output logic signed [ANGLE_W-1:0]  rsp_angle_q8,
   // register writes
   input  wire logic                  csr_valid,
   output logic                       csr_ready,
   input  wire logic [1:0]            csr_index,
   input  wire logic [COUNT_W-1:0]    csr_data
);
   cmd_type    cmd;
   status_type status;

   // config writes never stall
   assign csr_ready = 1'b1;

   eac_ctrl u_ctrl (
      .clock,
      .reset,
      .req_valid,
      .req_operation,
      .req_channel,
      .req_ready,
      .rsp_valid,
      .rsp_ready,
      .status,
      .cmd
   );

   eac_dpath #(
      .LEFT_MAP_DEPTH (LEFT_MAP_DEPTH),
      .RIGHT_MAP_DEPTH(RIGHT_MAP_DEPTH),
      .BASE_MAP_DEPTH (BASE_MAP_DEPTH)
   ) u_dpath (
      .clock,
      .reset,
      .cmd,
      .status,
      .req_operation,
      .req_channel,
      .req_sample_0,
      .req_sample_1,
      .req_sample_2,
      .req_sample_3,
      .req_sample_4,
      .req_map_index,
      .req_map_value,
      .csr_write(csr_valid && csr_ready),
      .csr_index,
      .csr_data,
      .rsp_result_channel,
      .rsp_mean_value,
      .rsp_angle_q8
   );

endmodule
`default_nettype wire
